// ===== sv/thermal_throttle_governor_defines.svh =====
// Assertion macros used by the governor's top module.
`ifndef THERMAL_THROTTLE_GOVERNOR_DEFINES_SVH
`define THERMAL_THROTTLE_GOVERNOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define TTG_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define TTG_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/ttg_pkg.sv =====
// Types, constants and codes of the thermal throttle governor.
package ttg_pkg;

	// Cores present and cores under control (at most four are controlled)
	localparam int NUM_CORES  = 4;
	localparam int CTRL_CORES = (NUM_CORES < 4) ? NUM_CORES : 4;
	localparam int MASK_W     = 4;
	localparam int CORE_W     = 2;
	localparam logic [MASK_W-1:0] CTRL_RANGE = MASK_W'((1 << CTRL_CORES) - 1);

	// Fixed temperature thresholds in degrees C
	localparam logic signed [9:0] HARD_LIMIT_TEMP = 10'sd80;
	localparam logic signed [9:0] IDLE_POLL_TEMP  = 10'sd45;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_STEP_DOWN_TEMP  = 3'd0,
		REG_TEMP_HYSTERESIS = 3'd1,
		REG_INDEX_STEP      = 3'd2,
		REG_MIN_INDEX       = 3'd3,
		REG_TOP_INDEX       = 3'd4,
		REG_CORE_LIMIT_TEMP = 3'd5,
		REG_CORE_HYSTERESIS = 3'd6,
		REG_CORE_CTRL_MASK  = 3'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		POLL_FAST   = 2'd0,
		POLL_NORMAL = 2'd1,
		POLL_SLOW   = 2'd2
	} poll_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_OFFLINE = 2'd1,
		ACT_ONLINE  = 2'd2
	} core_act_t;

	// Configuration register file
	typedef struct packed {
		logic [6:0]        step_down_temp;
		logic [5:0]        temp_hysteresis;
		logic [4:0]        index_step;
		logic [3:0]        min_index;
		logic [4:0]        top_index;
		logic [7:0]        core_limit_temp;
		logic [5:0]        core_hysteresis;
		logic [MASK_W-1:0] core_ctrl_mask;
	} cfg_t;

	// Governor state carried from item to item
	typedef struct packed {
		logic [4:0]        index;
		logic              throttle;
		logic [MASK_W-1:0] offlined;
		logic              initialized;
	} gov_state_t;

	// One input item
	typedef struct packed {
		logic [7:0]        temperature;
		logic              sensor_ok;
		logic [MASK_W-1:0] online_mask;
	} sample_t;

	// One result item
	typedef struct packed {
		logic [4:0]        limit_index;
		logic              limit_changed;
		logic              throttle_active;
		poll_t             poll_rate;
		core_act_t         core_action;
		logic [CORE_W-1:0] core_number;
		logic [MASK_W-1:0] offlined_mask;
	} result_t;

endpackage

// ===== sv/ttg_step.sv =====
// Next-state and result logic of the governor for one sample.
module ttg_step (
	input  ttg_pkg::cfg_t       cfg,
	input  ttg_pkg::gov_state_t cur,
	input  ttg_pkg::sample_t    smp,
	output ttg_pkg::gov_state_t nxt,
	output ttg_pkg::result_t    res
);
	import ttg_pkg::*;

	logic signed [9:0]  temp_x;
	logic signed [9:0]  warn_x;
	logic signed [9:0]  thr_x;
	logic signed [9:0]  climit_x;
	logic signed [9:0]  crel_x;
	logic [MASK_W-1:0]  cmask;
	logic [4:0]         min_x;
	logic [4:0]         idx0;

	// Extend all thresholds to one signed width
	assign temp_x   = {{2{smp.temperature[7]}}, smp.temperature};
	assign thr_x    = $signed({3'b000, cfg.step_down_temp});
	assign warn_x   = thr_x - $signed({4'b0000, cfg.temp_hysteresis});
	assign climit_x = {{2{cfg.core_limit_temp[7]}}, cfg.core_limit_temp};
	assign crel_x   = climit_x - $signed({4'b0000, cfg.core_hysteresis});
	assign cmask    = cfg.core_ctrl_mask & CTRL_RANGE;
	assign min_x    = {1'b0, cfg.min_index};
	assign idx0     = cur.initialized ? cur.index : cfg.top_index;

	// Core control, then the frequency limit, then the poll rate
	always_comb begin
		logic              found;
		logic              faster;
		logic [MASK_W-1:0] off;
		nxt             = cur;
		res.limit_changed = 1'b0;
		res.core_action = ACT_NONE;
		res.core_number = '0;
		res.poll_rate   = POLL_SLOW;
		found           = 1'b0;
		faster          = 1'b0;
		off             = cur.offlined;
		if (smp.sensor_ok) begin
			nxt.initialized = 1'b1;
			nxt.index       = idx0;
			if (temp_x >= HARD_LIMIT_TEMP) begin
				faster            = 1'b1;
				nxt.index         = min_x;
				nxt.throttle      = 1'b1;
				res.limit_changed = 1'b1;
			end else begin
				if (cmask != '0 && temp_x >= climit_x) begin
					// offline the highest eligible core, core 0 excluded
					for (int i = CTRL_CORES - 1; i > 0; i--) begin
						if (!found && cmask[i] && !(off[i] && !smp.online_mask[i])) begin
							found           = 1'b1;
							off[i]          = 1'b1;
							res.core_action = ACT_OFFLINE;
							res.core_number = CORE_W'(i);
						end
					end
				end else if (cmask != '0 && off != '0 && temp_x <= crel_x) begin
					// release upward, clearing bits until one core goes online
					for (int i = 0; i < CTRL_CORES; i++) begin
						if (!found && off[i]) begin
							off[i] = 1'b0;
							if (!smp.online_mask[i]) begin
								found           = 1'b1;
								res.core_action = ACT_ONLINE;
								res.core_number = CORE_W'(i);
							end
						end
					end
				end
				nxt.offlined = off;

				if (temp_x < warn_x) begin
					nxt.throttle = 1'b0;
					if (idx0 != cfg.top_index) begin
						nxt.index         = cfg.top_index;
						res.limit_changed = 1'b1;
					end
				end else if (temp_x >= thr_x) begin
					faster = 1'b1;
					if (idx0 != min_x) begin
						if (cfg.index_step > idx0 || (idx0 - cfg.index_step) < min_x) begin
							nxt.index = min_x;
						end else begin
							nxt.index = idx0 - cfg.index_step;
						end
						nxt.throttle      = 1'b1;
						res.limit_changed = 1'b1;
					end
				end else begin
					faster       = 1'b1;
					nxt.throttle = 1'b0;
					if (idx0 != cfg.top_index) begin
						nxt.index         = cfg.top_index;
						res.limit_changed = 1'b1;
					end
				end
			end
			if (temp_x > IDLE_POLL_TEMP) begin
				res.poll_rate = faster ? POLL_FAST : POLL_NORMAL;
			end
		end
		res.limit_index     = nxt.index;
		res.throttle_active = nxt.throttle;
		res.offlined_mask   = nxt.offlined;
	end

endmodule

// ===== sv/thermal_throttle_governor.sv =====
// A result is offered from the result register once its item has left the input register through the step logic.
// One item per cycle unless the output stalls; the step logic and the state update sit in one stage.
// The input register moves on whenever the result register is empty or being taken.
// Reset clears the state and valid flags and sets the configuration registers to their defaults at once.
// Configuration writes take effect at the next clock edge.
module thermal_throttle_governor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [2:0]                 cfg_index,
	input  logic [7:0]                 cfg_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 temperature,
	input  logic                       sensor_ok,
	input  logic [ttg_pkg::MASK_W-1:0] online_mask,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [4:0]                 limit_index,
	output logic                       limit_changed,
	output logic                       throttle_active,
	output logic [1:0]                 poll_rate,
	output logic [1:0]                 core_action,
	output logic [ttg_pkg::CORE_W-1:0] core_number,
	output logic [ttg_pkg::MASK_W-1:0] offlined_mask
);
	import ttg_pkg::*;
	`include "thermal_throttle_governor_defines.svh"

	cfg_t       cfg_q;
	gov_state_t state_q;
	gov_state_t state_nxt;
	sample_t    smp_s1;
	logic       valid_s1;
	result_t    res_comb;
	result_t    res_s2;
	logic       valid_s2;
	logic       adv;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_down_temp    <= 7'd70;
			cfg_q.temp_hysteresis   <= 6'd10;
			cfg_q.index_step        <= 5'd1;
			cfg_q.min_index         <= 4'd7;
			cfg_q.top_index         <= 5'd15;
			cfg_q.core_limit_temp   <= 8'd80;
			cfg_q.core_hysteresis   <= 6'd10;
			cfg_q.core_ctrl_mask    <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_STEP_DOWN_TEMP:  cfg_q.step_down_temp    <= cfg_data[6:0];
				REG_TEMP_HYSTERESIS: cfg_q.temp_hysteresis   <= cfg_data[5:0];
				REG_INDEX_STEP:      cfg_q.index_step        <= cfg_data[4:0];
				REG_MIN_INDEX:       cfg_q.min_index         <= cfg_data[3:0];
				REG_TOP_INDEX:       cfg_q.top_index         <= cfg_data[4:0];
				REG_CORE_LIMIT_TEMP: cfg_q.core_limit_temp   <= cfg_data;
				REG_CORE_HYSTERESIS: cfg_q.core_hysteresis   <= cfg_data[5:0];
				REG_CORE_CTRL_MASK:  cfg_q.core_ctrl_mask    <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance the input register when the result register frees up
	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	// Hold the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			smp_s1.temperature <= temperature;
			smp_s1.sensor_ok   <= sensor_ok;
			smp_s1.online_mask <= online_mask;
		end
	end

	ttg_step u_step (
		.cfg (cfg_q),
		.cur (state_q),
		.smp (smp_s1),
		.nxt (state_nxt),
		.res (res_comb)
	);

	// Update the governor state as each item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid       = valid_s2;
	assign limit_index     = res_s2.limit_index;
	assign limit_changed   = res_s2.limit_changed;
	assign throttle_active = res_s2.throttle_active;
	assign poll_rate       = res_s2.poll_rate;
	assign core_action     = res_s2.core_action;
	assign core_number     = res_s2.core_number;
	assign offlined_mask   = res_s2.offlined_mask;

	`TTG_ASSERT_IMP(a_idle_core_zero, out_valid && core_action == ACT_NONE, core_number == '0, "core number set without a core action")
	`TTG_ASSERT_IMP(a_offline_marked, out_valid && core_action == ACT_OFFLINE, offlined_mask[core_number] && core_number != '0, "offlined core not marked or is core 0")
	`TTG_ASSERT_IMP(a_online_cleared, out_valid && core_action == ACT_ONLINE, !offlined_mask[core_number], "released core still marked offline")
	`TTG_ASSERT_NXT(a_item_moves, valid_s1 && adv, out_valid, "item left the input register without a result")

endmodule

// ===== tb/tb.sv =====
// Testbench for the thermal throttle governor: directed and random samples, predictor checked.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ttg_pkg::*;

	localparam int CFG_BITS  = $bits(cfg_t);
	localparam int LONG_HOLD = 60;
	localparam int PHASES    = 12;
	localparam int PER_PHASE = 100;

	typedef struct packed {
		logic [7:0]        temp;
		logic              ok;
		logic [MASK_W-1:0] online;
		logic              typed;
		result_t           want;
	} sample_row_t;

	localparam cfg_t RESET_SETTINGS = '{7'd70, 6'd10, 5'd1, 4'd7, 5'd15, 8'd80, 6'd10, 4'h0};
	localparam cfg_t LOW_SETTINGS   = '{7'd45, 6'd0, 5'd1, 4'd4, 5'd5, 8'hD8, 6'd0, 4'h0};
	localparam cfg_t HIGH_SETTINGS  = '{7'd80, 6'd63, 5'd31, 4'd8, 5'd31, 8'd125, 6'd63, 4'hF};
	// Core control on, warning band bound below zero, step larger than the index
	localparam cfg_t CORE_SETTINGS  = '{7'd60, 6'd63, 5'd31, 4'd7, 5'd15, 8'd50, 6'd5, 4'hF};

	// Samples under the reset settings; obvious results typed in
	localparam sample_row_t RESET_ROWS [10] = '{
		'{8'hD8, 1'b0, 4'h0, 1'b1, '{5'd0, 1'b0, 1'b0, POLL_SLOW, ACT_NONE, 2'd0, 4'h0}},
		'{8'h7F, 1'b0, 4'hF, 1'b1, '{5'd0, 1'b0, 1'b0, POLL_SLOW, ACT_NONE, 2'd0, 4'h0}},
		'{8'd125, 1'b1, 4'hF, 1'b1, '{5'd7, 1'b1, 1'b1, POLL_FAST, ACT_NONE, 2'd0, 4'h0}},
		'{8'h80, 1'b1, 4'h0, 1'b1, '{5'd15, 1'b1, 1'b0, POLL_SLOW, ACT_NONE, 2'd0, 4'h0}},
		'{8'd70, 1'b1, 4'h5, 1'b0, '0},
		'{8'd65, 1'b1, 4'hA, 1'b0, '0},
		'{8'd80, 1'b1, 4'hF, 1'b1, '{5'd7, 1'b1, 1'b1, POLL_FAST, ACT_NONE, 2'd0, 4'h0}},
		'{8'd79, 1'b1, 4'hF, 1'b1, '{5'd7, 1'b0, 1'b1, POLL_FAST, ACT_NONE, 2'd0, 4'h0}},
		'{8'd45, 1'b1, 4'hF, 1'b0, '0},
		'{8'd46, 1'b1, 4'hF, 1'b0, '0}
	};

	// Samples that walk core offlining and release
	localparam sample_row_t CORE_ROWS [12] = '{
		'{8'd55, 1'b1, 4'hF, 1'b0, '0},
		'{8'd55, 1'b1, 4'h7, 1'b0, '0},
		'{8'd55, 1'b1, 4'h3, 1'b0, '0},
		'{8'd55, 1'b1, 4'h1, 1'b0, '0},
		'{8'd50, 1'b1, 4'hF, 1'b0, '0},
		'{8'd40, 1'b1, 4'hF, 1'b0, '0},
		'{8'd50, 1'b1, 4'hF, 1'b0, '0},
		'{8'd100, 1'b1, 4'h7, 1'b0, '0},
		'{8'hF6, 1'b1, 4'h7, 1'b0, '0},
		'{8'd60, 1'b1, 4'hF, 1'b0, '0},
		'{8'h7F, 1'b1, 4'hF, 1'b0, '0},
		'{8'h80, 1'b1, 4'hF, 1'b0, '0}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	cfg_reg_t            cfg_index = REG_STEP_DOWN_TEMP;
	logic [7:0]          cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [7:0]          temperature = '0;
	logic                sensor_ok = 1'b0;
	logic [MASK_W-1:0]   online_mask = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [4:0]          limit_index;
	logic                limit_changed;
	logic                throttle_active;
	logic [1:0]          poll_rate;
	logic [1:0]          core_action;
	logic [CORE_W-1:0]   core_number;
	logic [MASK_W-1:0]   offlined_mask;

	// Predictor copy of the registers and the governor state
	cfg_t              regs = RESET_SETTINGS;
	logic [4:0]        limit_q = '0;
	logic              throttling_q = 1'b0;
	logic [MASK_W-1:0] offline_q = '0;
	logic              primed_q = 1'b0;

	result_t expected_results[$];
	int      failures = 0;
	int      gap_odds = 4;
	int      stall_odds = 4;
	logic    hold_long = 1'b0;

	thermal_throttle_governor dut (.*);

	always #2 clk = ~clk;

	// Work out the result of one sample and advance the governor state
	function automatic result_t govern(logic [7:0] temp_raw, logic ok,
			logic [MASK_W-1:0] online);
		result_t           r;
		int                temp;
		int                warn;
		int                core_lim;
		int                i;
		logic [MASK_W-1:0] cmask;
		logic              faster;
		r = '0;
		r.poll_rate = POLL_SLOW;
		r.core_action = ACT_NONE;
		temp = int'($signed(temp_raw));
		if (ok) begin
			cmask = regs.core_ctrl_mask & CTRL_RANGE;
			warn = int'(regs.step_down_temp) - int'(regs.temp_hysteresis);
			core_lim = int'($signed(regs.core_limit_temp));
			faster = 1'b0;
			if (!primed_q) begin
				limit_q = regs.top_index;
				primed_q = 1'b1;
			end
			if (temp >= int'(HARD_LIMIT_TEMP)) begin
				// hard limit: pin to the minimum, no core control
				faster = 1'b1;
				limit_q = 5'(regs.min_index);
				throttling_q = 1'b1;
				r.limit_changed = 1'b1;
			end else begin
				// take the highest eligible core offline, never core 0
				if (cmask != 0 && temp >= core_lim) begin
					for (i = CTRL_CORES - 1; i > 0; i--) begin
						if (r.core_action == ACT_NONE && cmask[i] &&
								!(offline_q[i] && !online[i])) begin
							offline_q[i] = 1'b1;
							r.core_action = ACT_OFFLINE;
							r.core_number = CORE_W'(i);
						end
					end
				end else if (cmask != 0 && offline_q != 0 &&
						temp <= core_lim - int'(regs.core_hysteresis)) begin
					// release upward, clearing each offlined bit passed
					for (i = 0; i < CTRL_CORES; i++) begin
						if (r.core_action == ACT_NONE && offline_q[i]) begin
							offline_q[i] = 1'b0;
							if (!online[i]) begin
								r.core_action = ACT_ONLINE;
								r.core_number = CORE_W'(i);
							end
						end
					end
				end
				// frequency limit
				if (temp < warn) begin
					throttling_q = 1'b0;
					if (limit_q != regs.top_index) begin
						limit_q = regs.top_index;
						r.limit_changed = 1'b1;
					end
				end else if (temp >= int'(regs.step_down_temp)) begin
					faster = 1'b1;
					if (limit_q != 5'(regs.min_index)) begin
						if (int'(regs.index_step) > int'(limit_q) ||
								int'(limit_q) - int'(regs.index_step) < int'(regs.min_index))
							limit_q = 5'(regs.min_index);
						else
							limit_q = limit_q - regs.index_step;
						throttling_q = 1'b1;
						r.limit_changed = 1'b1;
					end
				end else begin
					faster = 1'b1;
					throttling_q = 1'b0;
					if (limit_q != regs.top_index) begin
						limit_q = regs.top_index;
						r.limit_changed = 1'b1;
					end
				end
			end
			if (temp > int'(IDLE_POLL_TEMP))
				r.poll_rate = faster ? POLL_FAST : POLL_NORMAL;
		end
		r.limit_index = limit_q;
		r.throttle_active = throttling_q;
		r.offlined_mask = offline_q;
		return r;
	endfunction

	// Offer one item, hold it until accepted, then log its expected result
	task automatic offer_sample(logic [7:0] t, logic ok, logic [MASK_W-1:0] online,
			logic typed, result_t want);
		result_t predicted;
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		temperature <= t;
		sensor_ok <= ok;
		online_mask <= online;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = govern(t, ok, online);
		expected_results.push_back(typed ? want : predicted);
	endtask

	// Stop offering and wait until every result is back
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			REG_STEP_DOWN_TEMP:  regs.step_down_temp = v[6:0];
			REG_TEMP_HYSTERESIS: regs.temp_hysteresis = v[5:0];
			REG_INDEX_STEP:      regs.index_step = v[4:0];
			REG_MIN_INDEX:       regs.min_index = v[3:0];
			REG_TOP_INDEX:       regs.top_index = v[4:0];
			REG_CORE_LIMIT_TEMP: regs.core_limit_temp = v;
			REG_CORE_HYSTERESIS: regs.core_hysteresis = v[5:0];
			REG_CORE_CTRL_MASK:  regs.core_ctrl_mask = v[MASK_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(cfg_t s);
		write_reg(REG_STEP_DOWN_TEMP, 8'(s.step_down_temp));
		write_reg(REG_TEMP_HYSTERESIS, 8'(s.temp_hysteresis));
		write_reg(REG_INDEX_STEP, 8'(s.index_step));
		write_reg(REG_MIN_INDEX, 8'(s.min_index));
		write_reg(REG_TOP_INDEX, 8'(s.top_index));
		write_reg(REG_CORE_LIMIT_TEMP, s.core_limit_temp);
		write_reg(REG_CORE_HYSTERESIS, 8'(s.core_hysteresis));
		write_reg(REG_CORE_CTRL_MASK, 8'(s.core_ctrl_mask));
		cfg_we <= 1'b0;
	endtask

	// Extremes first, then legal random settings, and a couple of raw bit patterns
	function automatic cfg_t pick_settings(int phase);
		cfg_t s;
		if (phase == 0)
			s = LOW_SETTINGS;
		else if (phase == 1)
			s = HIGH_SETTINGS;
		else if (phase == 8 || phase == 9)
			s = cfg_t'(CFG_BITS'({$urandom(), $urandom()}));
		else begin
			s.step_down_temp = 7'($urandom_range(45, 80));
			s.temp_hysteresis = 6'($urandom_range(0, 63));
			s.index_step = 5'($urandom_range(1, 31));
			s.min_index = 4'($urandom_range(4, 8));
			s.top_index = 5'($urandom_range(int'(s.min_index) + 1, 31));
			s.core_limit_temp = 8'(int'($urandom_range(0, 165)) - 40);
			s.core_hysteresis = 6'($urandom_range(0, 63));
			s.core_ctrl_mask = MASK_W'($urandom_range(0, 15));
		end
		return s;
	endfunction

	// Aim temperatures at the thresholds the current settings define
	function automatic logic [7:0] pick_temp();
		int base;
		int t;
		case ($urandom_range(0, 6))
			0: base = int'(regs.step_down_temp);
			1: base = int'(regs.step_down_temp) - int'(regs.temp_hysteresis);
			2: base = int'($signed(regs.core_limit_temp));
			3: base = int'($signed(regs.core_limit_temp)) - int'(regs.core_hysteresis);
			4: base = int'(HARD_LIMIT_TEMP);
			5: base = int'(IDLE_POLL_TEMP);
			default: return 8'($urandom_range(0, 255));
		endcase
		t = base + int'($urandom_range(0, 6)) - 3;
		if (t > 127)
			t = 127;
		if (t < -128)
			t = -128;
		return 8'(t);
	endfunction

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endtask

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_long) begin
				hold_long = 1'b0;
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: limit_index %0d", limit_index);
				failures++;
			end else begin
				want = expected_results.pop_front();
				check_field("limit_index", 8'(want.limit_index), 8'(limit_index));
				check_field("limit_changed", 8'(want.limit_changed), 8'(limit_changed));
				check_field("throttle_active", 8'(want.throttle_active), 8'(throttle_active));
				check_field("poll_rate", 8'(want.poll_rate), 8'(poll_rate));
				check_field("core_action", 8'(want.core_action), 8'(core_action));
				check_field("core_number", 8'(want.core_number), 8'(core_number));
				check_field("offlined_mask", 8'(want.offlined_mask), 8'(offlined_mask));
			end
		end
	end

	// Stimulus
	initial begin
		logic [7:0]        t;
		logic              ok;
		logic [MASK_W-1:0] online;
		int                n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (RESET_ROWS[k])
			offer_sample(RESET_ROWS[k].temp, RESET_ROWS[k].ok, RESET_ROWS[k].online,
				RESET_ROWS[k].typed, RESET_ROWS[k].want);
		drain();
		apply_settings(CORE_SETTINGS);
		foreach (CORE_ROWS[k])
			offer_sample(CORE_ROWS[k].temp, CORE_ROWS[k].ok, CORE_ROWS[k].online,
				CORE_ROWS[k].typed, CORE_ROWS[k].want);

		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_settings(pick_settings(phase));
			// vary idling; the last phase runs without any
			if (phase == PHASES - 1 || phase % 3 == 1) begin
				gap_odds = 0;
				stall_odds = 0;
			end else if (phase % 3 == 0) begin
				gap_odds = 4;
				stall_odds = 4;
			end else begin
				gap_odds = 2;
				stall_odds = 8;
			end
			for (n = 0; n < PER_PHASE; n++) begin
				if (phase == 3 && n == 20)
					hold_long = 1'b1;
				if (phase == 5 && n == 50)
					drain();
				t = pick_temp();
				ok = ($urandom_range(0, 9) != 0);
				// half the time keep offlined cores offline, otherwise anything
				if ($urandom_range(0, 1) == 0)
					online = MASK_W'($urandom_range(0, 15));
				else
					online = ~offline_q;
				if ($urandom_range(0, 7) == 0)
					online[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
				offer_sample(t, ok, online, 1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		for (n = 0; n < 5000 && expected_results.size() != 0; n++)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			failures++;
		end
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+sv
sv/ttg_pkg.sv
sv/ttg_step.sv
sv/thermal_throttle_governor.sv
tb/tb.sv
